### rtl/nsq_pkg.sv
// ----------------------------------------------------------------------------
// nsq_pkg
// Shared sizes, codes, types and helper functions of the scale value
// quantizer pipeline.
// ----------------------------------------------------------------------------
package nsq_pkg;

    // table and value geometry
    localparam int TABLE_DEPTH = 16;
    localparam int VALUE_WIDTH = 24;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // fixed field widths
    localparam int CFG_W       = 4;
    localparam int ENTRY_W     = 4;
    localparam int CFG_IDX_W   = 1;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W   = ((ENTRY_W + VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;

    // probe stages needed until the bracket shrinks to neighbors
    localparam int N_PROBE     = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH - 1) : 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX  = 1'b1;

    // action codes carried in tuser
    localparam logic ACTION_QUERY = 1'b0;
    localparam logic ACTION_LOAD  = 1'b1;

    typedef logic        [IDX_W-1:0]       t_idx;
    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    // one item as it travels down the pipeline
    typedef struct packed {
        logic   is_load;
        logic   wr_ok;
        t_idx   waddr;
        t_value x;
        t_idx   lo;
        t_idx   hi;
        t_idx   mid;
        t_value sl;
        t_value sh;
        logic   done;
        t_value res;
    } t_item;

    // saturate a configured position to the table
    function automatic t_idx clamp_idx(input logic [CFG_W-1:0] v);
        if (int'(v) >= TABLE_DEPTH) begin
            return IDX_W'(TABLE_DEPTH - 1);
        end
        return IDX_W'(v);
    endfunction

    // middle position of a bracket, rounded toward the lower bound
    function automatic t_idx mid_idx(input t_idx lo, input t_idx hi);
        t_idx d;
        d = hi - lo;
        return lo + (d >> 1);
    endfunction

endpackage

### rtl/nearest_scale_value_quantizer.sv
// A query result passes the entry stage, then four probe stages and the output
// register before it is shown on the master side.
// Throughput: one item per cycle unless the result stream stalls; each probe stage
// owns a table copy, so the search depth of N_PROBE probes is spread over the stages.
// Reset clears the stage valid bits and both search bounds to zero; table
// entries are undefined until loaded and get no clearing pass.
// ----------------------------------------------------------------------------
// nearest_scale_value_quantizer
// Pitch quantizer: snaps a Q4.20 sample to the nearest value of a loaded,
// ascending scale table over a configured range of positions.
// ----------------------------------------------------------------------------
module nearest_scale_value_quantizer
    import nsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // entry_index, sample_value, zero pad
    input  logic                  s_axis_tuser,  // action
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // quantized_value, zero pad
);

    logic [CFG_W-1:0] r_first_index;
    logic [CFG_W-1:0] r_last_index;

    logic  w_valid [N_PROBE+1];
    logic  w_ready [N_PROBE+1];
    t_item w_item  [N_PROBE+1];
    t_item w_last;

    logic   r_out_valid;
    t_value r_out_data;
    t_value n_out_data;
    logic   w_out_ready;
    logic signed [VALUE_WIDTH:0] w_dist_lo;
    logic signed [VALUE_WIDTH:0] w_dist_hi;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_index <= '0;
            r_last_index  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FIRST_INDEX: r_first_index <= i_cfg_data;
                REG_LAST_INDEX:  r_last_index  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry stage
    nsq_entry u_entry (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_entry_index (s_axis_tdata[ENTRY_W-1:0]),
        .i_sample      ($signed(s_axis_tdata[ENTRY_W +: VALUE_WIDTH])),
        .i_lo          (clamp_idx(r_first_index)),
        .i_hi          (clamp_idx(r_last_index)),
        .o_valid       (w_valid[0]),
        .i_ready       (w_ready[0]),
        .o_item        (w_item[0])
    );

    // search stages
    for (genvar k = 0; k < N_PROBE; k++) begin : g_probe
        nsq_probe u_probe (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    assign w_last      = w_item[N_PROBE];
    assign w_out_ready = !r_out_valid || m_axis_tready;
    assign w_ready[N_PROBE] = w_out_ready;

    // pick the nearer neighbor, a tie going to the upper one
    assign w_dist_lo = {w_last.x[VALUE_WIDTH-1], w_last.x}
                     - {w_last.sl[VALUE_WIDTH-1], w_last.sl};
    assign w_dist_hi = {w_last.sh[VALUE_WIDTH-1], w_last.sh}
                     - {w_last.x[VALUE_WIDTH-1], w_last.x};

    always_comb begin
        priority if (w_last.done) begin
            n_out_data = w_last.res;
        end else if (w_dist_lo < w_dist_hi) begin
            n_out_data = w_last.sl;
        end else begin
            n_out_data = w_last.sh;
        end
    end

    // output register, loads are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[N_PROBE] && !w_last.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_valid[N_PROBE] && !w_last.is_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'($unsigned(r_out_data));

`ifndef SYNTHESIS
    // an open search has shrunk to neighbors by the last stage
    a_converged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[N_PROBE] && !w_last.is_load && !w_last.done)
        |-> ((w_last.hi - w_last.lo) == IDX_W'(1)))
        else $error("search bracket not narrowed to neighbors");

    // an open search always brackets the input
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[N_PROBE] && !w_last.is_load && !w_last.done)
        |-> (($signed(w_last.sl) <= $signed(w_last.x))
            && ($signed(w_last.x) <= $signed(w_last.sh))))
        else $error("search bracket lost the input");

    // back pressure only starts at a stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_out_valid && !m_axis_tready))
        else $error("input stalled without a stalled result");
`endif

endmodule

### rtl/nsq_ram.sv
// ----------------------------------------------------------------------------
// nsq_ram
// Generic single write, single read memory with a registered read port.
// ----------------------------------------------------------------------------
module nsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/nsq_entry.sv
// ----------------------------------------------------------------------------
// nsq_entry
// Entry stage: takes an item, fetches the entries at both search bounds and
// resolves the range checks that come before the search.
// ----------------------------------------------------------------------------
module nsq_entry
    import nsq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  t_value             i_sample,
    input  t_idx               i_lo,
    input  t_idx               i_hi,
    output logic               o_valid,
    input  logic               i_ready,
    output t_item              o_item
);

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   w_take;
    logic   w_we;
    logic [VALUE_WIDTH-1:0] w_rd_lo;
    logic [VALUE_WIDTH-1:0] w_rd_hi;
    t_value w_sl;
    t_value w_sh;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // item as captured into the stage
    always_comb begin
        n_item         = '0;
        n_item.is_load = (i_action == ACTION_LOAD);
        n_item.wr_ok   = (int'(i_entry_index) < TABLE_DEPTH);
        n_item.waddr   = IDX_W'(i_entry_index);
        n_item.x       = i_sample;
        n_item.lo      = i_lo;
        n_item.hi      = i_hi;
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    // table copies for the two bounds, written as a load enters
    assign w_we = w_take && n_item.is_load && n_item.wr_ok;

    nsq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (n_item.waddr),
        .i_wdata ($unsigned(n_item.x)),
        .i_re    (w_take),
        .i_raddr (i_lo),
        .o_rdata (w_rd_lo)
    );

    nsq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (n_item.waddr),
        .i_wdata ($unsigned(n_item.x)),
        .i_re    (w_take),
        .i_raddr (i_hi),
        .o_rdata (w_rd_hi)
    );

    assign w_sl = $signed(w_rd_lo);
    assign w_sh = $signed(w_rd_hi);

    // range checks ahead of the search, in their fixed order
    always_comb begin
        o_item      = r_item;
        o_item.sl   = w_sl;
        o_item.sh   = w_sh;
        o_item.done = 1'b1;
        o_item.res  = w_sl;
        priority if (w_sl > r_item.x) begin
            o_item.res = w_sl;
        end else if (w_sh < r_item.x) begin
            o_item.res = w_sh;
        end else if (r_item.hi == r_item.lo) begin
            o_item.res = w_sl;
        end else if (r_item.hi < r_item.lo) begin
            o_item.res = r_item.x;
        end else begin
            o_item.done = 1'b0;
        end
        o_item.mid = mid_idx(r_item.lo, r_item.hi);
    end

    assign o_valid = r_valid;

endmodule

### rtl/nsq_probe.sv
// ----------------------------------------------------------------------------
// nsq_probe
// One search stage: probes the middle of the bracket in its own table copy
// and keeps the half that holds the input, or ends the search on a match.
// ----------------------------------------------------------------------------
module nsq_probe
    import nsq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic   r_valid;
    t_item  r_item;
    logic   w_take;
    logic [VALUE_WIDTH-1:0] w_rd;
    t_value w_sm;
    t_idx   w_span;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    // table copy of this stage, kept in step with the item order
    nsq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_take && i_item.is_load && i_item.wr_ok),
        .i_waddr (i_item.waddr),
        .i_wdata ($unsigned(i_item.x)),
        .i_re    (w_take && !i_item.is_load),
        .i_raddr (i_item.mid),
        .o_rdata (w_rd)
    );

    assign w_sm   = $signed(w_rd);
    assign w_span = r_item.hi - r_item.lo;

    // narrow the bracket around the input
    always_comb begin
        o_item = r_item;
        if (!r_item.is_load && !r_item.done && (w_span > IDX_W'(1))) begin
            priority if (w_sm == r_item.x) begin
                o_item.done = 1'b1;
                o_item.res  = r_item.x;
            end else if (w_sm > r_item.x) begin
                o_item.hi = r_item.mid;
                o_item.sh = w_sm;
            end else begin
                o_item.lo = r_item.mid;
                o_item.sl = w_sm;
            end
        end
        o_item.mid = mid_idx(o_item.lo, o_item.hi);
    end

    assign o_valid = r_valid;

endmodule
